// File: hdl/vna_pkg.sv
// Package for the vertex normal accumulator: command codes, widths, request types.
// No dependencies; every other file but the checker imports it.
package vna_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int VW = $clog2(VERTEX_DEPTH);
    localparam int SUM_W = 20;
    localparam int POS_W = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // One classified request between the front and the back.
    typedef struct packed {
        logic [1:0]         command;
        logic               in_range;
        logic [9:0]         vertex_a;
        logic [9:0]         vertex_b;
        logic [9:0]         vertex_c;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } req_t;

    // Control between the back sequencer and the normalize unit.
    typedef struct packed {
        logic start;
    } norm_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_sts_t;

endpackage

// File: hdl/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: front queue plus back engine.
// Depends on vna_pkg, vna_front and vna_back.
//
//   Channel   Handshake        Payload
//   request   push / full      command, vertex_a..c, pos_x..z
//   result    pop / empty      vertex_id, normal_x..z, zero_normal
//
// A load is written in the back part as it leaves the queue; a read and a triangle
// in range go through the normalize unit, a bitwise square root, then three divisions.
// After reset the back part clears all 1024 normal sums; positions are not cleared
// and the queue takes up to four requests meanwhile.
// A four-entry queue keeps accepting requests while the back part works,
// and a read waits at the head of the queue while the result register is full.
module vertex_normal_accumulator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            command,
    input  logic [9:0]            vertex_a,
    input  logic [9:0]            vertex_b,
    input  logic [9:0]            vertex_c,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic signed [15:0]    pos_z,
    output logic                  empty,
    input  logic                  pop,
    output logic [9:0]            vertex_id,
    output logic signed [15:0]    normal_x,
    output logic signed [15:0]    normal_y,
    output logic signed [15:0]    normal_z,
    output logic                  zero_normal
);
    import vna_pkg::*;

    logic q_valid;
    logic q_take;
    req_t q_req;

    vna_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .vertex_a(vertex_a), .vertex_b(vertex_b),
        .vertex_c(vertex_c), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
    );

    vna_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_take(q_take), .empty(empty), .pop(pop), .vertex_id(vertex_id),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .zero_normal(zero_normal)
    );
endmodule

// File: hdl/vna_front.sv
// Front part: accepts requests, checks index range, and queues them for the back.
// Depends on vna_pkg.
module vna_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            command,
    input  logic [9:0]            vertex_a,
    input  logic [9:0]            vertex_b,
    input  logic [9:0]            vertex_c,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic signed [15:0]    pos_z,
    output logic                  q_valid,
    output vna_pkg::req_t         q_req,
    input  logic                  q_take
);
    import vna_pkg::*;

    localparam int QD = 4;

    req_t       q_reg [QD];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    req_t       req_in;
    logic       do_push;
    logic       do_pop;

    // Classify the incoming request.
    always_comb
    begin
        req_in.command  = command;
        req_in.vertex_a = vertex_a;
        req_in.vertex_b = vertex_b;
        req_in.vertex_c = vertex_c;
        req_in.pos_x    = pos_x;
        req_in.pos_y    = pos_y;
        req_in.pos_z    = pos_z;
        req_in.in_range = (32'(vertex_a) < VERTEX_DEPTH)
            && ((command != CMD_TRI) || ((32'(vertex_b) < VERTEX_DEPTH)
            && (32'(vertex_c) < VERTEX_DEPTH)));
    end

    assign full    = (cnt_reg == 3'(QD));
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 3'd0);
    assign do_pop  = q_take && q_valid;
    assign q_req   = q_reg[rp_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= req_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(do_push) - 3'(do_pop);
        end
    end
endmodule

// File: hdl/vna_norm.sv
// Normalize unit: scales a signed vector to unit length in Q1.14 with an
// iterative square root and an iterative divider. Depends on vna_pkg.
module vna_norm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vna_pkg::norm_ctl_t      ctl,
    input  logic signed [33:0]      vx,
    input  logic signed [33:0]      vy,
    input  logic signed [33:0]      vz,
    output vna_pkg::norm_sts_t      sts,
    output logic signed [15:0]      nx,
    output logic signed [15:0]      ny,
    output logic signed [15:0]      nz
);
    import vna_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SQ = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  st_reg;
    logic [33:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [1:0]  idx_reg;
    logic [63:0] acc_reg;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [46:0] num_reg;
    logic [32:0] drem_reg;
    logic [15:0] q_reg;
    logic [15:0] res_reg [3];
    logic        zero_reg;
    logic        done_reg;

    logic [33:0] maxm;
    logic [61:0] sq;
    logic [65:0] trial;
    logic [63:0] rem_sh;
    logic [33:0] drem_sh;
    logic [33:0] dtrial;

    // OR of the three magnitudes, the one square of this step, and the root and divider trials.
    always_comb
    begin
        maxm = m_reg[0] | m_reg[1] | m_reg[2];
        sq = 62'(m_reg[idx_reg][30:0]) * 62'(m_reg[idx_reg][30:0]);
        rem_sh = {rem_reg[61:0], acc_reg[63:62]};
        trial = {2'b0, rem_sh} - {32'b0, root_reg, 2'b01};
        drem_sh = {drem_reg, num_reg[46]};
        dtrial = drem_sh - {1'b0, root_reg, 1'b0};
    end

    assign sts.done = done_reg;
    assign sts.zero = zero_reg;
    assign nx = res_reg[0];
    assign ny = res_reg[1];
    assign nz = res_reg[2];

    // Sequencer: shift, sum of squares, bitwise root, restoring division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        m_reg[0] <= vx[33] ? 34'(-vx) : vx;
                        m_reg[1] <= vy[33] ? 34'(-vy) : vy;
                        m_reg[2] <= vz[33] ? 34'(-vz) : vz;
                        neg_reg <= {vz[33], vy[33], vx[33]};
                        st_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (maxm == 34'd0)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        zero_reg <= 1'b1;
                        done_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                    else if (maxm[33:30] != 4'd0)
                    begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end
                    else
                    begin
                        idx_reg <= 2'd0;
                        acc_reg <= '0;
                        st_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    acc_reg <= acc_reg + 64'(sq);
                    if (idx_reg == 2'd2)
                    begin
                        rem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg <= '0;
                        st_reg <= S_ROOT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                S_ROOT:
                begin
                    acc_reg <= {acc_reg[61:0], 2'b00};
                    if (!trial[65])
                    begin
                        rem_reg <= trial[63:0];
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == 6'd31)
                    begin
                        idx_reg <= 2'd0;
                        cnt_reg <= '0;
                        st_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    // Quotient of (2*m*16384 + L) / (2*L), one bit per cycle.
                    if (cnt_reg == 6'd0)
                    begin
                        num_reg <= 47'({m_reg[idx_reg][30:0], 15'b0}) + 47'(root_reg);
                        drem_reg <= '0;
                        q_reg <= '0;
                        cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        num_reg <= {num_reg[45:0], 1'b0};
                        if (!dtrial[33])
                        begin
                            drem_reg <= dtrial[32:0];
                            q_reg <= {q_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= drem_sh[32:0];
                            q_reg <= {q_reg[14:0], 1'b0};
                        end
                        if (cnt_reg == 6'd47)
                        begin
                            res_reg[idx_reg] <= neg_reg[idx_reg]
                                ? 16'(-{q_reg[14:0], !dtrial[33]})
                                : {q_reg[14:0], !dtrial[33]};
                            cnt_reg <= '0;
                            if (idx_reg == 2'd2)
                            begin
                                zero_reg <= 1'b0;
                                done_reg <= 1'b1;
                                st_reg <= S_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: hdl/vna_back.sv
// Back part: position and sum memories, cross product, accumulation, read results.
// Depends on vna_pkg and vna_norm.
module vna_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  vna_pkg::req_t         q_req,
    output logic                  q_take,
    output logic                  empty,
    input  logic                  pop,
    output logic [9:0]            vertex_id,
    output logic signed [15:0]    normal_x,
    output logic signed [15:0]    normal_y,
    output logic signed [15:0]    normal_z,
    output logic                  zero_normal
);
    import vna_pkg::*;

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_RDP   = 4'd1;
    localparam logic [3:0] B_WAITP = 4'd2;
    localparam logic [3:0] B_EDGE  = 4'd3;
    localparam logic [3:0] B_MUL   = 4'd4;
    localparam logic [3:0] B_SUB   = 4'd5;
    localparam logic [3:0] B_NORM  = 4'd6;
    localparam logic [3:0] B_RDS   = 4'd7;
    localparam logic [3:0] B_WAITS = 4'd8;
    localparam logic [3:0] B_WRS   = 4'd9;
    localparam logic [3:0] B_READ  = 4'd10;
    localparam logic [3:0] B_RNORM = 4'd11;
    localparam logic [3:0] B_OUT   = 4'd12;
    localparam logic [3:0] B_CLR   = 4'd13;

    logic [47:0] pos_mem [VERTEX_DEPTH];
    logic [59:0] sum_mem [VERTEX_DEPTH];

    logic [3:0]  st_reg;
    req_t        r_reg;
    logic [1:0]  k_reg;
    logic [VW-1:0] clr_reg;
    logic [VW-1:0] p_addr;
    logic [47:0] p_rd_reg;
    logic [VW-1:0] s_addr;
    logic [VW-1:0] s_wa;
    logic [59:0] s_rd_reg;
    logic        s_we;
    logic [59:0] s_wd;
    logic        p_we;
    logic signed [15:0] pa_reg [3];
    logic signed [15:0] pb_reg [3];
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [33:0] pr_reg [6];
    logic signed [33:0] cr_reg [3];
    logic signed [15:0] n_reg [3];
    logic        out_full_reg;
    logic [9:0]  o_id_reg;
    logic signed [15:0] o_n_reg [3];
    logic        o_z_reg;
    norm_ctl_t   nctl;
    norm_sts_t   nsts;
    logic signed [15:0] nnx, nny, nnz;
    logic signed [20:0] add [3];
    logic signed [19:0] sat [3];
    logic [9:0]  vsel;
    logic        read_mode;

    vna_norm u_norm (
        .clk(clk), .rst_n(rst_n), .ctl(nctl),
        .vx(cr_reg[0]), .vy(cr_reg[1]), .vz(cr_reg[2]),
        .sts(nsts), .nx(nnx), .ny(nny), .nz(nnz)
    );

    // Corner select, saturating sums, memory write controls and queue take for the current step.
    always_comb
    begin
        case (k_reg)
            2'd0: vsel = r_reg.vertex_a;
            2'd1: vsel = r_reg.vertex_b;
            default: vsel = r_reg.vertex_c;
        endcase
        p_addr = VW'(vsel);
        s_addr = VW'(vsel);
        for (int i = 0; i < 3; i++)
        begin
            add[i] = 21'(signed'(s_rd_reg[i*20 +: 20])) + 21'(n_reg[i]);
            if (add[i] > 21'sd524287)
                sat[i] = 20'sd524287;
            else if (add[i] < -21'sd524288)
                sat[i] = 20'sh80000;
            else
                sat[i] = add[i][19:0];
        end
        // Loads and the clearing pass write zero; accumulation writes the sum.
        s_wd = (st_reg == B_WRS) ? {sat[2], sat[1], sat[0]} : 60'b0;
        s_we = (st_reg == B_WRS) || (st_reg == B_CLR) || (st_reg == B_IDLE && q_valid
            && q_req.command == CMD_LOAD && q_req.in_range);
        if (st_reg == B_WRS)
            s_wa = s_addr;
        else if (st_reg == B_CLR)
            s_wa = clr_reg;
        else
            s_wa = VW'(q_req.vertex_a);
        p_we = (st_reg == B_IDLE && q_valid && q_req.command == CMD_LOAD
            && q_req.in_range);
        nctl.start = (st_reg == B_RNORM);
        q_take = (st_reg == B_IDLE) && q_valid
            && !(q_req.command == CMD_READ && out_full_reg);
    end

    // Memories, registered reads.
    always_ff @(posedge clk)
    begin
        if (p_we)
            pos_mem[VW'(q_req.vertex_a)] <= {q_req.pos_z, q_req.pos_y, q_req.pos_x};
        p_rd_reg <= pos_mem[p_addr];
        if (s_we)
            sum_mem[s_wa] <= s_wd;
        s_rd_reg <= sum_mem[(st_reg == B_IDLE) ? VW'(q_req.vertex_a) : s_addr];
    end

    assign read_mode = (r_reg.command == CMD_READ);
    assign empty = !out_full_reg;
    assign vertex_id = o_id_reg;
    assign normal_x = o_n_reg[0];
    assign normal_y = o_n_reg[1];
    assign normal_z = o_n_reg[2];
    assign zero_normal = o_z_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_CLR;
            out_full_reg <= 1'b0;
            k_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (pop && out_full_reg)
                out_full_reg <= 1'b0;
            case (st_reg)
                B_CLR:
                begin
                    // Zero one sum entry per cycle after reset.
                    clr_reg <= clr_reg + VW'(1);
                    if (clr_reg == VW'(VERTEX_DEPTH - 1))
                        st_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (q_take)
                    begin
                        r_reg <= q_req;
                        k_reg <= 2'd0;
                        if (q_req.command == CMD_TRI && q_req.in_range)
                            st_reg <= B_RDP;
                        else if (q_req.command == CMD_READ)
                            st_reg <= q_req.in_range ? B_READ : B_OUT;
                        if (q_req.command == CMD_READ)
                        begin
                            for (int i = 0; i < 3; i++)
                                cr_reg[i] <= '0;
                        end
                    end
                end
                B_READ:
                begin
                    // Sum read was issued in idle; it is valid now.
                    for (int i = 0; i < 3; i++)
                        cr_reg[i] <= 34'(signed'(s_rd_reg[i*20 +: 20]));
                    st_reg <= B_RNORM;
                end
                B_RNORM:
                begin
                    // The vector is settled; the normalize unit starts here.
                    st_reg <= B_NORM;
                end
                B_RDP:
                begin
                    st_reg <= B_WAITP;
                end
                B_WAITP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (k_reg == 2'd0)
                            pa_reg[i] <= signed'(p_rd_reg[i*16 +: 16]);
                        else if (k_reg == 2'd1)
                            pb_reg[i] <= signed'(p_rd_reg[i*16 +: 16]);
                        else
                            e2_reg[i] <= 17'(signed'(p_rd_reg[i*16 +: 16])) - 17'(pa_reg[i]);
                    end
                    if (k_reg == 2'd2)
                        st_reg <= B_EDGE;
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        st_reg <= B_RDP;
                    end
                end
                B_EDGE:
                begin
                    for (int i = 0; i < 3; i++)
                        e1_reg[i] <= 17'(pb_reg[i]) - 17'(pa_reg[i]);
                    st_reg <= B_MUL;
                end
                B_MUL:
                begin
                    pr_reg[0] <= 34'(e1_reg[1]) * 34'(e2_reg[2]);
                    pr_reg[1] <= 34'(e1_reg[2]) * 34'(e2_reg[1]);
                    pr_reg[2] <= 34'(e1_reg[2]) * 34'(e2_reg[0]);
                    pr_reg[3] <= 34'(e1_reg[0]) * 34'(e2_reg[2]);
                    pr_reg[4] <= 34'(e1_reg[0]) * 34'(e2_reg[1]);
                    pr_reg[5] <= 34'(e1_reg[1]) * 34'(e2_reg[0]);
                    st_reg <= B_SUB;
                end
                B_SUB:
                begin
                    if (!read_mode)
                    begin
                        cr_reg[0] <= pr_reg[0] - pr_reg[1];
                        cr_reg[1] <= pr_reg[2] - pr_reg[3];
                        cr_reg[2] <= pr_reg[4] - pr_reg[5];
                    end
                    st_reg <= B_RNORM;
                end
                B_NORM:
                begin
                    if (nsts.done)
                    begin
                        if (read_mode)
                        begin
                            o_n_reg[0] <= nnx;
                            o_n_reg[1] <= nny;
                            o_n_reg[2] <= nnz;
                            o_z_reg <= nsts.zero;
                            o_id_reg <= r_reg.vertex_a;
                            out_full_reg <= 1'b1;
                            st_reg <= B_IDLE;
                        end
                        else if (nsts.zero)
                            st_reg <= B_IDLE;
                        else
                        begin
                            n_reg[0] <= nnx;
                            n_reg[1] <= nny;
                            n_reg[2] <= nnz;
                            k_reg <= 2'd0;
                            st_reg <= B_RDS;
                        end
                    end
                end
                B_RDS:
                begin
                    st_reg <= B_WAITS;
                end
                B_WAITS:
                begin
                    st_reg <= B_WRS;
                end
                B_WRS:
                begin
                    if (k_reg == 2'd2)
                        st_reg <= B_IDLE;
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        st_reg <= B_RDS;
                    end
                end
                B_OUT:
                begin
                    o_n_reg[0] <= '0;
                    o_n_reg[1] <= '0;
                    o_n_reg[2] <= '0;
                    o_z_reg <= 1'b1;
                    o_id_reg <= r_reg.vertex_a;
                    out_full_reg <= 1'b1;
                    st_reg <= B_IDLE;
                end
                default:
                begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule

// File: hdl/vna_checker.sv
// Port checker for the vertex normal accumulator, bound to the top level.
// Depends on the top level's ports only.
module vna_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [9:0]         vertex_id,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic               zero_normal
);
    // A waiting result stays present, with its vertex_id and normal_x, until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(vertex_id) && $stable(normal_x)))
        else $error("result changed while waiting");

    // A zero flag comes with zero components.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_normal) |-> (normal_x == 16'sd0 && normal_y == 16'sd0
            && normal_z == 16'sd0))
        else $error("zero flag with nonzero normal");

    // normal_x stays within the unit range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384))
        else $error("normal_x out of range");

    // No result and room for requests at the first clock edge that sees reset released.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> (empty && !full))
        else $error("result present or queue full after reset");
endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .vertex_id(vertex_id), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .zero_normal(zero_normal)
);
